/* rtl/cdm_pkg.sv */
// Package with request codes, register indexes, states and shared types of the matcher.
`default_nettype none
package cdm_pkg;
	localparam int unsigned ELEM_W  = 8;
	localparam int unsigned DIST_W  = 23;
	localparam int unsigned HALF_TURN = 11520;
	localparam int unsigned FULL_TURN = 23040;

	typedef enum logic [1:0] {
		REQ_REF_ELEM  = 2'd0,
		REQ_REF_GEOM  = 2'd1,
		REQ_QRY_ELEM  = 2'd2,
		REQ_RUN       = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		REG_SCALE_LIMIT = 3'd0,
		REG_ANGLE_LIMIT = 3'd1,
		REG_RADIUS      = 3'd2,
		REG_REF_COUNT   = 3'd3,
		REG_DESC_LEN    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEOM,
		ST_GATE,
		ST_ACCUM,
		ST_DRAIN,
		ST_DECIDE,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // perform a load request on the accepted input
		logic start;      // latch query geometry, clear the best match
		logic geom_rd;    // read geometry of the current reference
		logic gate;       // evaluate gates on registered geometry
		logic elem_rd;    // issue a descriptor element read
		logic acc_clr;    // clear the distance accumulator
		logic decide;     // compare current distance against the best
		logic next_ref;   // advance to the next reference
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pass;       // gates passed for the current reference
		logic last_ref;   // current reference is the last one to scan
		logic no_refs;    // nothing to scan
		logic last_elem;  // last descriptor element is being issued
		logic zero_len;   // descriptor length is zero
		logic acc_busy;   // reads still in flight to the accumulator
		logic found;      // a best match exists
	} status_t;
endpackage
`default_nettype wire

/* rtl/cdm_stream_if.sv */
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface cdm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/cdm_ctrl.sv */
// Sequencer state machine for loads and the reference scan.
`default_nettype none
module cdm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        in_type,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cdm_pkg::cmd_t          cmd,
	input  wire cdm_pkg::status_t  sts
);
	cdm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cdm_pkg::ST_IDLE: begin
				if (in_valid && in_type == cdm_pkg::REQ_RUN) begin
					state_d = sts.no_refs ? cdm_pkg::ST_IDLE : cdm_pkg::ST_GEOM;
				end
			end
			cdm_pkg::ST_GEOM: state_d = cdm_pkg::ST_GATE;
			cdm_pkg::ST_GATE: begin
				if (sts.pass) begin
					state_d = sts.zero_len ? cdm_pkg::ST_DRAIN : cdm_pkg::ST_ACCUM;
				end else if (sts.last_ref) begin
					state_d = sts.found ? cdm_pkg::ST_RESULT : cdm_pkg::ST_IDLE;
				end else begin
					state_d = cdm_pkg::ST_GEOM;
				end
			end
			cdm_pkg::ST_ACCUM: begin
				if (sts.last_elem) state_d = cdm_pkg::ST_DRAIN;
			end
			cdm_pkg::ST_DRAIN: begin
				if (!sts.acc_busy) state_d = cdm_pkg::ST_DECIDE;
			end
			cdm_pkg::ST_DECIDE: begin
				state_d = sts.last_ref ? cdm_pkg::ST_RESULT : cdm_pkg::ST_GEOM;
			end
			cdm_pkg::ST_RESULT: begin
				if (out_ready) state_d = cdm_pkg::ST_IDLE;
			end
			default: state_d = cdm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			cdm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = (in_type != cdm_pkg::REQ_RUN);
					cmd.start = (in_type == cdm_pkg::REQ_RUN);
				end
			end
			cdm_pkg::ST_GEOM: begin
				cmd.geom_rd = 1'b1;
			end
			cdm_pkg::ST_GATE: begin
				cmd.gate    = 1'b1;
				cmd.acc_clr = 1'b1;
				if (!sts.pass) cmd.next_ref = 1'b1;
			end
			cdm_pkg::ST_ACCUM: cmd.elem_rd = 1'b1;
			cdm_pkg::ST_DRAIN: cmd = '0;
			cdm_pkg::ST_DECIDE: begin
				cmd.decide   = 1'b1;
				cmd.next_ref = 1'b1;
			end
			cdm_pkg::ST_RESULT: out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/cdm_datapath.sv */
// Storage, gate arithmetic, descriptor distance accumulator and best-match tracking.
`default_nettype none
module cdm_datapath #(
	parameter int unsigned MAX_REFERENCES = 1024,
	parameter int unsigned MAX_DESC_LEN   = 128,
	parameter int unsigned ELEMENT_BITS   = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cdm_pkg::cmd_t     cmd,
	output cdm_pkg::status_t       sts,
	input  wire logic [1:0]        req_type,
	input  wire logic [9:0]        feature_slot,
	input  wire logic [6:0]        element_index,
	input  wire logic [7:0]        element_value,
	input  wire logic [15:0]       pos_x,
	input  wire logic [15:0]       pos_y,
	input  wire logic [15:0]       feature_scale,
	input  wire logic [14:0]       feature_angle,
	input  wire logic [15:0]       query_id,
	input  wire logic [15:0]       scale_ratio_limit,
	input  wire logic [13:0]       angle_limit,
	input  wire logic [15:0]       search_radius,
	input  wire logic [10:0]       reference_count,
	input  wire logic [7:0]        descriptor_length,
	output logic [15:0]            match_query,
	output logic [9:0]             match_reference,
	output logic [22:0]            match_distance
);
	localparam int unsigned RW = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
	localparam int unsigned CW = $clog2(MAX_REFERENCES + 1);
	localparam int unsigned EW = (MAX_DESC_LEN > 1) ? $clog2(MAX_DESC_LEN) : 1;
	localparam int unsigned LW = $clog2(MAX_DESC_LEN + 1);
	localparam int unsigned SQW = 2 * ELEMENT_BITS;
	localparam int unsigned AW = SQW + LW;
	localparam int unsigned GW = 63;
	localparam logic [AW-1:0] DIST_SAT = AW'((64'd1 << cdm_pkg::DIST_W) - 64'd1);

	// Memories. The descriptor store is addressed by {reference, element}, so every
	// reference owns a power-of-two block of element slots.
	logic [ELEMENT_BITS-1:0] ref_desc_mem [MAX_REFERENCES << EW];
	logic [GW-1:0]           geom_mem [MAX_REFERENCES];
	logic [ELEMENT_BITS-1:0] qry_mem [MAX_DESC_LEN];

	logic [ELEMENT_BITS-1:0] val_m;
	logic slot_ok, elem_ok;
	assign val_m   = ELEMENT_BITS'(element_value);
	assign slot_ok = (32'(feature_slot) < MAX_REFERENCES);
	assign elem_ok = (32'(element_index) < MAX_DESC_LEN);

	// Scan registers.
	logic [RW-1:0] ref_q;
	logic [EW-1:0] elem_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] len_q;
	logic [15:0]   qx_q, qy_q, qs_q, qid_q;
	logic [14:0]   qa_q;

	logic [CW-1:0] count_c;
	logic [LW-1:0] len_c;
	assign count_c = (32'(reference_count) > MAX_REFERENCES) ? CW'(MAX_REFERENCES)
		: CW'(reference_count);
	assign len_c = (32'(descriptor_length) > MAX_DESC_LEN) ? LW'(MAX_DESC_LEN)
		: LW'(descriptor_length);

	always_ff @(posedge clk) begin
		if (cmd.load && req_type == cdm_pkg::REQ_REF_ELEM && slot_ok && elem_ok) begin
			ref_desc_mem[{RW'(feature_slot), EW'(element_index)}] <= val_m;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load && req_type == cdm_pkg::REQ_REF_GEOM && slot_ok) begin
			geom_mem[RW'(feature_slot)] <= {pos_x, pos_y, feature_scale, feature_angle};
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load && req_type == cdm_pkg::REQ_QRY_ELEM && elem_ok) begin
			qry_mem[EW'(element_index)] <= val_m;
		end
	end

	// Geometry read, registered.
	logic [GW-1:0] geom_s1;
	always_ff @(posedge clk) begin
		if (cmd.geom_rd) geom_s1 <= geom_mem[ref_q];
	end

	// Descriptor element reads, registered, with a valid pipe.
	logic [ELEMENT_BITS-1:0] rd_s1, qd_s1;
	logic [SQW-1:0]          sq_s2;
	logic                    v_s1, v_s2;
	always_ff @(posedge clk) begin
		if (cmd.elem_rd) begin
			rd_s1 <= ref_desc_mem[{ref_q, elem_q}];
			qd_s1 <= qry_mem[elem_q];
		end
	end

	logic [ELEMENT_BITS-1:0] ed;
	assign ed = (rd_s1 > qd_s1) ? rd_s1 - qd_s1 : qd_s1 - rd_s1;
	always_ff @(posedge clk) begin
		sq_s2 <= SQW'(ed) * SQW'(ed);
	end

	logic [AW-1:0] acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.elem_rd;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + AW'(sq_s2);
	end

	// Gates on the registered geometry.
	logic [15:0] gx, gy, gs;
	logic [14:0] ga;
	assign {gx, gy, gs, ga} = geom_s1;
	logic [15:0] dx, dy;
	logic [32:0] r2sum;
	logic [31:0] rad2;
	assign dx = (gx > qx_q) ? gx - qx_q : qx_q - gx;
	assign dy = (gy > qy_q) ? gy - qy_q : qy_q - gy;
	assign r2sum = 33'(dx * dx) + 33'(dy * dy);
	assign rad2  = search_radius * search_radius;
	logic [15:0] hi, lo;
	logic [23:0] hi_sh;
	logic [31:0] lim_lo;
	assign hi = (gs > qs_q) ? gs : qs_q;
	assign lo = (gs > qs_q) ? qs_q : gs;
	assign hi_sh = {hi, 8'd0};
	assign lim_lo = scale_ratio_limit * lo;
	logic signed [16:0] ad, ad_w;
	logic [15:0] agap;
	always_comb begin
		ad = $signed({2'b0, ga}) - $signed({2'b0, qa_q});
		ad_w = ad;
		if (ad > 17'sd11520) ad_w = ad - 17'sd23040;
		else if (ad < -17'sd11520) ad_w = ad + 17'sd23040;
		agap = (ad_w < 0) ? 16'(-ad_w) : 16'(ad_w);
	end
	logic pass_c;
	assign pass_c = (r2sum <= 33'(rad2))
		&& (scale_ratio_limit == '0 || 32'(hi_sh) <= lim_lo)
		&& (angle_limit == '0 || agap <= 16'(angle_limit));

	// Best match.
	logic          found_q;
	logic [RW-1:0] best_q;
	logic [AW-1:0] best_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			ref_q   <= '0;
			elem_q  <= '0;
		end else begin
			if (cmd.start) begin
				found_q <= 1'b0;
				ref_q   <= '0;
			end else if (cmd.next_ref) begin
				ref_q <= ref_q + RW'(1);
			end
			if (cmd.acc_clr) elem_q <= '0;
			else if (cmd.elem_rd) elem_q <= elem_q + EW'(1);
			if (cmd.decide && (!found_q || acc_q < best_dist_q)) found_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q    <= pos_x;
			qy_q    <= pos_y;
			qs_q    <= feature_scale;
			qa_q    <= feature_angle;
			qid_q   <= query_id;
			count_q <= count_c;
			len_q   <= len_c;
		end
		if (cmd.decide && (!found_q || acc_q < best_dist_q)) begin
			best_q      <= ref_q;
			best_dist_q <= acc_q;
		end
	end

	assign sts.pass      = pass_c;
	assign sts.last_ref  = (CW'(ref_q) + CW'(1) >= count_q);
	assign sts.no_refs   = (count_c == '0);
	assign sts.last_elem = (LW'(elem_q) + LW'(1) >= len_q);
	assign sts.zero_len  = (len_q == '0);
	assign sts.acc_busy  = v_s1 || v_s2;
	assign sts.found     = found_q || (pass_c && cmd.gate && 1'b0);

	assign match_query     = qid_q;
	assign match_reference = 10'(best_q);
	assign match_distance  = (best_dist_q > DIST_SAT) ? 23'(DIST_SAT) : 23'(best_dist_q);
endmodule
`default_nettype wire

/* rtl/constrained_descriptor_matcher.sv */
// Top level of the constrained descriptor matcher: ports, register file and wiring.
// Load requests are taken back to back while idle; during a run the single-port descriptor
// memory is read one element per cycle.
// One run is processed at a time; the result is held until taken.
// arst_n clears control state and the registers to their reset values; stores are
// undefined until written.
`default_nettype none
module constrained_descriptor_matcher #(
	parameter int unsigned MAX_REFERENCES = 1024,
	parameter int unsigned MAX_DESC_LEN   = 128,
	parameter int unsigned ELEMENT_BITS   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	cdm_stream_if.sink       req,
	cdm_stream_if.source     rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	// Configuration registers, written on the APB access cycle.
	logic [15:0] scale_limit_q;
	logic [13:0] angle_limit_q;
	logic [15:0] radius_q;
	logic [10:0] ref_count_q;
	logic [7:0]  desc_len_q;
	cdm_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign widx   = cdm_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_limit_q <= 16'd512;
			angle_limit_q <= '0;
			radius_q      <= 16'd3200;
			ref_count_q   <= '0;
			desc_len_q    <= 8'd128;
		end else if (psel && penable && pwrite) begin
			case (widx)
				cdm_pkg::REG_SCALE_LIMIT: scale_limit_q <= pwdata[15:0];
				cdm_pkg::REG_ANGLE_LIMIT: angle_limit_q <= pwdata[13:0];
				cdm_pkg::REG_RADIUS:      radius_q      <= pwdata[15:0];
				cdm_pkg::REG_REF_COUNT:   ref_count_q   <= pwdata[10:0];
				cdm_pkg::REG_DESC_LEN:    desc_len_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data for the register at paddr.
	always_comb begin
		case (widx)
			cdm_pkg::REG_SCALE_LIMIT: prdata = 32'(scale_limit_q);
			cdm_pkg::REG_ANGLE_LIMIT: prdata = 32'(angle_limit_q);
			cdm_pkg::REG_RADIUS:      prdata = 32'(radius_q);
			cdm_pkg::REG_REF_COUNT:   prdata = 32'(ref_count_q);
			cdm_pkg::REG_DESC_LEN:    prdata = 32'(desc_len_q);
			default:                  prdata = '0;
		endcase
	end

	cdm_pkg::cmd_t    cmd;
	cdm_pkg::status_t sts;

	// The controller sequences loads, the reference scan and the result handoff.
	cdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_type   (req.data.req_type),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the stores, the gate arithmetic and the best match.
	cdm_datapath #(
		.MAX_REFERENCES (MAX_REFERENCES),
		.MAX_DESC_LEN   (MAX_DESC_LEN),
		.ELEMENT_BITS   (ELEMENT_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_type          (req.data.req_type),
		.feature_slot      (req.data.feature_slot),
		.element_index     (req.data.element_index),
		.element_value     (req.data.element_value),
		.pos_x             (req.data.pos_x),
		.pos_y             (req.data.pos_y),
		.feature_scale     (req.data.feature_scale),
		.feature_angle     (req.data.feature_angle),
		.query_id          (req.data.query_id),
		.scale_ratio_limit (scale_limit_q),
		.angle_limit       (angle_limit_q),
		.search_radius     (radius_q),
		.reference_count   (ref_count_q),
		.descriptor_length (desc_len_q),
		.match_query       (rsp.data.match_query),
		.match_reference   (rsp.data.match_reference),
		.match_distance    (rsp.data.match_distance)
	);
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench of the constrained descriptor matcher: stimulus, predictor, checks.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	// Request and result payloads as the block sees them on its channels.
	typedef struct packed {
		cdm_pkg::req_type_t req_type;
		logic [9:0]  feature_slot;
		logic [6:0]  element_index;
		logic [7:0]  element_value;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] feature_scale;
		logic [14:0] feature_angle;
		logic [15:0] query_id;
	} match_req_t;

	typedef struct packed {
		logic [15:0] match_query;
		logic [9:0]  match_reference;
		logic [22:0] match_distance;
	} match_rsp_t;

	localparam int unsigned N_REFS   = 1024;
	localparam int unsigned N_ELEMS  = 128;
	localparam int unsigned N_ITEMS  = 580;

	// The scoreboard holds its own copy of the stores and registers, predicts the match of
	// every accepted run and compares each result against the oldest prediction.
	class match_scoreboard;
		logic [7:0]  ref_desc [N_REFS*N_ELEMS];
		logic [15:0] geo_x [N_REFS];
		logic [15:0] geo_y [N_REFS];
		logic [15:0] geo_s [N_REFS];
		logic [14:0] geo_a [N_REFS];
		logic [7:0]  qry_desc [N_ELEMS];
		logic [15:0] scale_limit;
		logic [13:0] angle_limit;
		logic [15:0] radius;
		logic [10:0] ref_count;
		logic [7:0]  desc_len;
		match_rsp_t  pending_matches [$];
		int unsigned mismatches;
		int unsigned errors;

		function new();
			scale_limit = 16'd512;
			angle_limit = 14'd0;
			radius      = 16'd3200;
			ref_count   = 11'd0;
			desc_len    = 8'd128;
			mismatches  = 0;
			errors      = 0;
		endfunction

		function void set_reg(cdm_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				cdm_pkg::REG_SCALE_LIMIT: scale_limit = value[15:0];
				cdm_pkg::REG_ANGLE_LIMIT: angle_limit = value[13:0];
				cdm_pkg::REG_RADIUS:      radius      = value[15:0];
				cdm_pkg::REG_REF_COUNT:   ref_count   = value[10:0];
				cdm_pkg::REG_DESC_LEN:    desc_len    = value[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned scan_count();
			return (ref_count > N_REFS) ? N_REFS : ref_count;
		endfunction

		function int unsigned scan_len();
			return (desc_len > N_ELEMS) ? N_ELEMS : desc_len;
		endfunction

		// Geometric gates of one reference against the query geometry.
		function bit gates_pass(int unsigned slot, logic [15:0] qx, logic [15:0] qy,
				logic [15:0] qs, logic [14:0] qa);
			longint dx, dy, hi, lo, gap;
			dx = longint'(geo_x[slot]) - longint'(qx);
			dy = longint'(geo_y[slot]) - longint'(qy);
			if (dx * dx + dy * dy > longint'(radius) * longint'(radius))
				return 0;
			if (scale_limit != 0) begin
				hi = (geo_s[slot] > qs) ? longint'(geo_s[slot]) : longint'(qs);
				lo = (geo_s[slot] > qs) ? longint'(qs) : longint'(geo_s[slot]);
				if (hi * 256 > longint'(scale_limit) * lo)
					return 0;
			end
			if (angle_limit != 0) begin
				// The wrap is corrected once, so angles past a full turn stay large.
				gap = longint'(geo_a[slot]) - longint'(qa);
				if (gap > longint'(cdm_pkg::HALF_TURN))
					gap -= longint'(cdm_pkg::FULL_TURN);
				if (gap < -longint'(cdm_pkg::HALF_TURN))
					gap += longint'(cdm_pkg::FULL_TURN);
				if (gap < 0)
					gap = -gap;
				if (gap > longint'(angle_limit))
					return 0;
			end
			return 1;
		endfunction

		function void note_request(match_req_t r);
			longint best_dist, ref_dist, d;
			int unsigned best;
			bit found;
			match_rsp_t m;
			case (r.req_type)
				cdm_pkg::REQ_REF_ELEM:
					ref_desc[r.feature_slot*N_ELEMS + r.element_index] = r.element_value;
				cdm_pkg::REQ_REF_GEOM: begin
					geo_x[r.feature_slot] = r.pos_x;
					geo_y[r.feature_slot] = r.pos_y;
					geo_s[r.feature_slot] = r.feature_scale;
					geo_a[r.feature_slot] = r.feature_angle;
				end
				cdm_pkg::REQ_QRY_ELEM: qry_desc[r.element_index] = r.element_value;
				default: begin
					found = 0;
					best = 0;
					best_dist = 0;
					for (int unsigned i = 0; i < scan_count(); i++) begin
						if (!gates_pass(i, r.pos_x, r.pos_y, r.feature_scale, r.feature_angle))
							continue;
						ref_dist = 0;
						for (int unsigned k = 0; k < scan_len(); k++) begin
							d = longint'(qry_desc[k]) - longint'(ref_desc[i*N_ELEMS + k]);
							ref_dist += d * d;
						end
						// Strict less-than keeps the lowest index on ties.
						if (!found || ref_dist < best_dist) begin
							found = 1;
							best = i;
							best_dist = ref_dist;
						end
					end
					if (found) begin
						if (best_dist > 8388607)
							best_dist = 8388607;
						m.match_query     = r.query_id;
						m.match_reference = best[9:0];
						m.match_distance  = best_dist[22:0];
						pending_matches = {pending_matches, m};
					end
				end
			endcase
		endfunction

		function void check_match(match_rsp_t got);
			match_rsp_t want;
			if (pending_matches.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result: query %0d reference %0d distance %0d",
						got.match_query, got.match_reference, got.match_distance);
				return;
			end
			want = pending_matches.pop_front();
			if (got.match_query !== want.match_query ||
					got.match_reference !== want.match_reference ||
					got.match_distance !== want.match_distance) begin
				errors++;
				if (mismatches++ < 10)
					$display("mismatch: expected q %0d r %0d d %0d, got q %0d r %0d d %0d",
						want.match_query, want.match_reference, want.match_distance,
						got.match_query, got.match_reference, got.match_distance);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cdm_stream_if #(.payload_t(match_req_t)) req_ch ();
	cdm_stream_if #(.payload_t(match_rsp_t)) rsp_ch ();

	constrained_descriptor_matcher i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	match_scoreboard sb = new();

	// Stimulus-side record of which store entries hold a value, so that no run ever reads
	// an entry that was never written.
	bit geo_written [N_REFS];
	bit desc_written [N_REFS*N_ELEMS];
	bit qry_written [N_ELEMS];

	int unsigned sent_count;
	int unsigned last_cost;   // cycles the block may still be busy after the last request
	bit          sink_quiet;  // receiver takes results without gaps
	bit          sender_quiet;
	bit          hold_request;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Limit on the whole run, well beyond the slowest correct one.
	initial begin
		#80_000_000;
		$display("simulation failed");
		$finish;
	end

	// Sender: draws a gap, then offers the request until the block takes it.
	task automatic send(match_req_t item);
		int unsigned gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(item);
		sent_count++;
	endtask

	function automatic match_req_t blank_request(cdm_pkg::req_type_t kind);
		match_req_t r;
		r.req_type      = kind;
		r.feature_slot  = 10'($urandom);
		r.element_index = 7'($urandom);
		r.element_value = 8'($urandom);
		r.pos_x         = 16'($urandom);
		r.pos_y         = 16'($urandom);
		r.feature_scale = 16'($urandom);
		r.feature_angle = 15'($urandom);
		r.query_id      = 16'($urandom);
		return r;
	endfunction

	task automatic load_geom(int unsigned slot, logic [15:0] x, logic [15:0] y,
			logic [15:0] s, logic [14:0] a);
		match_req_t r;
		r = blank_request(cdm_pkg::REQ_REF_GEOM);
		r.feature_slot  = 10'(slot);
		r.pos_x         = x;
		r.pos_y         = y;
		r.feature_scale = s;
		r.feature_angle = a;
		geo_written[slot] = 1'b1;
		last_cost = 2;
		send(r);
	endtask

	task automatic load_ref_elem(int unsigned slot, int unsigned k, logic [7:0] v);
		match_req_t r;
		r = blank_request(cdm_pkg::REQ_REF_ELEM);
		r.feature_slot  = 10'(slot);
		r.element_index = 7'(k);
		r.element_value = v;
		desc_written[slot*N_ELEMS + k] = 1'b1;
		last_cost = 2;
		send(r);
	endtask

	task automatic load_qry_elem(int unsigned k, logic [7:0] v);
		match_req_t r;
		r = blank_request(cdm_pkg::REQ_QRY_ELEM);
		r.element_index = 7'(k);
		r.element_value = v;
		qry_written[k] = 1'b1;
		last_cost = 2;
		send(r);
	endtask

	// Issues a run. Any entry that the run would read and that was never written is first
	// loaded with a random value; the busy time of the run is estimated for idle waits.
	task automatic run_query(logic [15:0] x, logic [15:0] y, logic [15:0] s,
			logic [14:0] a, logic [15:0] id);
		match_req_t r;
		int unsigned cost;
		for (int unsigned k = 0; k < sb.scan_len(); k++)
			if (!qry_written[k])
				load_qry_elem(k, 8'($urandom));
		cost = 8;
		for (int unsigned i = 0; i < sb.scan_count(); i++) begin
			if (!geo_written[i])
				load_geom(i, 16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
					15'($urandom_range(0, 23039)));
			if (sb.gates_pass(i, x, y, s, a)) begin
				for (int unsigned k = 0; k < sb.scan_len(); k++)
					if (!desc_written[i*N_ELEMS + k])
						load_ref_elem(i, k, 8'($urandom));
				cost += sb.scan_len() + 6;
			end else begin
				cost += 3;
			end
		end
		r = blank_request(cdm_pkg::REQ_RUN);
		r.pos_x         = x;
		r.pos_y         = y;
		r.feature_scale = s;
		r.feature_angle = a;
		r.query_id      = id;
		send(r);
		last_cost = cost;
	endtask

	// Waits until every predicted result has arrived and the block has had time to finish
	// a run that produces no result.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (sb.pending_matches.size() != 0)
			@(posedge clk);
		repeat (last_cost + 20) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle; pready is always high.
	task automatic write_reg(cdm_pkg::reg_idx_t idx, logic [31:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	// Receiver: draws a stall for every result; once on request it holds off for a long
	// stretch so the block fills up and stops taking requests.
	initial begin : receiver
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			gap = sink_quiet ? 0 : $urandom_range(0, 19);
			if (hold_request) begin
				hold_request = 0;
				gap = 3000;
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			sb.check_match(rsp_ch.data);
		end
	end

	function automatic logic [15:0] near(logic [15:0] center, int unsigned span);
		int v;
		v = int'(center) + int'($urandom_range(0, 2 * span)) - int'(span);
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// One random phase: new register settings, a fresh set of references, then mostly runs
	// near the loaded references with some stray loads mixed in.
	task automatic random_phase(bit with_hold);
		int unsigned cnt, span, slot;
		logic [15:0] cx, cy, qs;
		case ($urandom_range(0, 5))
			0: write_reg(cdm_pkg::REG_SCALE_LIMIT, 0);
			1: write_reg(cdm_pkg::REG_SCALE_LIMIT, 65535);
			2: write_reg(cdm_pkg::REG_SCALE_LIMIT, 256);
			default: write_reg(cdm_pkg::REG_SCALE_LIMIT, $urandom_range(256, 1024));
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(cdm_pkg::REG_ANGLE_LIMIT, 0);
			1: write_reg(cdm_pkg::REG_ANGLE_LIMIT, 11520);
			2: write_reg(cdm_pkg::REG_ANGLE_LIMIT, 16383);
			default: write_reg(cdm_pkg::REG_ANGLE_LIMIT, $urandom_range(1, 11520));
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(cdm_pkg::REG_RADIUS, 1);
			1: write_reg(cdm_pkg::REG_RADIUS, 65535);
			default: write_reg(cdm_pkg::REG_RADIUS, $urandom_range(16, 4000));
		endcase
		cnt = $urandom_range(1, 12);
		write_reg(cdm_pkg::REG_REF_COUNT, cnt);
		case ($urandom_range(0, 7))
			0: write_reg(cdm_pkg::REG_DESC_LEN, 0);
			1: write_reg(cdm_pkg::REG_DESC_LEN, $urandom_range(17, 40));
			default: write_reg(cdm_pkg::REG_DESC_LEN, $urandom_range(1, 16));
		endcase
		sender_quiet = ($urandom_range(0, 3) == 0);
		sink_quiet   = ($urandom_range(0, 3) == 0);
		span = (sb.radius > 3000) ? 3000 : sb.radius;
		cx = 16'($urandom_range(4000, 60000));
		cy = 16'($urandom_range(4000, 60000));
		for (int unsigned i = 0; i < cnt; i++)
			load_geom(i, near(cx, span), near(cy, span),
				($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(128, 1024)),
				($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039)));
		for (int unsigned n = 0; n < 12; n++) begin
			if (with_hold && n == 2)
				hold_request = 1;
			slot = $urandom_range(0, cnt - 1);
			case ($urandom_range(0, 9))
				0: load_ref_elem(slot, $urandom_range(0, sb.scan_len() ? sb.scan_len() - 1 : 0),
					8'($urandom));
				1: load_qry_elem($urandom_range(0, 127), 8'($urandom));
				2: load_geom(slot, near(cx, span), near(cy, span), 16'($urandom),
					15'($urandom));
				default: begin
					qs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(128, 1024));
					run_query(near(sb.geo_x[slot], span / 2), near(sb.geo_y[slot], span / 2), qs,
						($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039)),
						16'($urandom));
				end
			endcase
		end
	endtask

	initial begin : stimulus
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.data   <= '0;
		rsp_ch.ready  <= 1'b0;
		sent_count    = 0;
		last_cost     = 2;
		sink_quiet    = 0;
		sender_quiet  = 0;
		hold_request  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A run with no references to scan gives no result.
		run_query(16'd1000, 16'd1000, 16'd256, 15'd100, 16'hFFFF);

		// Four references: one on the query, one exactly on the radius with a wrapped angle,
		// one at exactly twice the scale and one with zero scale.
		write_reg(cdm_pkg::REG_RADIUS, 100);
		write_reg(cdm_pkg::REG_REF_COUNT, 4);
		write_reg(cdm_pkg::REG_DESC_LEN, 2);
		load_geom(0, 16'd1000, 16'd1000, 16'd256, 15'd0);
		load_geom(1, 16'd1100, 16'd1000, 16'd256, 15'd23000);
		load_geom(2, 16'd1000, 16'd1000, 16'd512, 15'd100);
		load_geom(3, 16'd1000, 16'd1060, 16'd0, 15'd0);
		load_ref_elem(0, 0, 8'd255);
		load_ref_elem(0, 1, 8'd0);
		load_ref_elem(1, 0, 8'd255);
		load_ref_elem(1, 1, 8'd0);
		load_ref_elem(2, 0, 8'd0);
		load_ref_elem(2, 1, 8'd255);
		load_ref_elem(1023, 127, 8'd255);
		load_qry_elem(0, 8'd255);
		load_qry_elem(1, 8'd0);
		load_qry_elem(127, 8'd0);
		// Equal distances on references 0 and 1: the lower index must win.
		run_query(16'd1000, 16'd1000, 16'd256, 15'd100, 16'd0);
		write_reg(cdm_pkg::REG_ANGLE_LIMIT, 200);
		run_query(16'd1000, 16'd1000, 16'd256, 15'd100, 16'd1);
		run_query(16'd1000, 16'd1000, 16'd256, 15'd32767, 16'd2);
		// Zero length makes every distance zero.
		write_reg(cdm_pkg::REG_DESC_LEN, 0);
		run_query(16'd1000, 16'd1000, 16'd512, 15'd23039, 16'd3);
		// Scale gate off; then a zero query scale with the gate on.
		write_reg(cdm_pkg::REG_SCALE_LIMIT, 0);
		write_reg(cdm_pkg::REG_ANGLE_LIMIT, 0);
		run_query(16'd1000, 16'd1000, 16'd0, 15'd0, 16'd4);
		write_reg(cdm_pkg::REG_SCALE_LIMIT, 65535);
		run_query(16'd1000, 16'd1000, 16'd0, 15'd0, 16'd5);
		write_reg(cdm_pkg::REG_ANGLE_LIMIT, 11520);
		write_reg(cdm_pkg::REG_RADIUS, 65535);
		run_query(16'd65535, 16'd65535, 16'd65535, 15'd0, 16'd6);

		// An oversized length scans the full descriptor; only the first reference is near.
		write_reg(cdm_pkg::REG_SCALE_LIMIT, 0);
		write_reg(cdm_pkg::REG_ANGLE_LIMIT, 0);
		write_reg(cdm_pkg::REG_RADIUS, 16);
		write_reg(cdm_pkg::REG_REF_COUNT, 2);
		write_reg(cdm_pkg::REG_DESC_LEN, 255);
		sender_quiet = 1;
		load_geom(0, 16'd60000, 16'd60000, 16'($urandom), 15'($urandom));
		load_geom(1, 16'd0, 16'd0, 16'($urandom), 15'($urandom));
		run_query(16'd60000, 16'd60000, 16'd256, 15'd0, 16'd7);
		run_query(16'd60005, 16'd60000, 16'd256, 15'd0, 16'd8);
		sender_quiet = 0;

		// Random phases; one of them holds the receiver off for a long stretch.
		for (int unsigned p = 0; sent_count < N_ITEMS; p++)
			random_phase(p == 1);

		wait_idle();
		if (sb.errors == 0 && sb.pending_matches.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
